FILE: rtl/core/barometric_pressure_compensation_core_macros.svh
// Assertion helpers for the compensation core.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication
`define BPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned DIV_STEPS = 32;

  localparam logic [31:0] TEMP_OFFSET = 32'd4000;
  localparam logic [31:0] P_COEF_SQ   = 32'd3038;
  localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_COEF_OFS  = 32'd3791;
  localparam logic [31:0] P_SCALE     = 32'd50000;
  localparam logic [31:0] X3_BIAS     = 32'd32768;
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_CAL_A = 2'd0,
    CFG_CAL_B = 2'd1,
    CFG_CAL_C = 2'd2,
    CFG_OSS   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } div_state_t;

  typedef struct packed {
    logic        fault;
    logic        neg;
    logic [31:0] x1t;
    logic [18:0] up;
    logic [31:0] dvs;
  } div1_side_t;

  typedef struct packed {
    logic        fault;
    logic        shl;
    logic [15:0] ts;
    logic [31:0] dvs;
  } div2_side_t;

  typedef struct packed {
    logic        fault;
    logic [15:0] ts;
    logic [18:0] up;
  } press_side_t;

  function automatic logic [31:0] asr(logic [31:0] v, int unsigned n);
    logic signed [31:0] s;
    s = $signed(v) >>> n;
    return $unsigned(s);
  endfunction

  // one restoring step: next dividend bit in, one quotient bit out
  function automatic div_state_t div_step(div_state_t s, logic [31:0] dvs);
    logic [32:0] t;
    div_state_t  n;
    t = {s.rem, s.quo[31]};
    if (t >= {1'b0, dvs}) begin
      n.rem = t[31:0] - dvs;
      n.quo = {s.quo[30:0], 1'b1};
    end else begin
      n.rem = t[31:0];
      n.quo = {s.quo[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic [15:0] sat16(logic [31:0] t);
    logic [15:0] r;
    if ($signed(t) < -32'sd32768) begin
      r = 16'h8000;
    end else if ($signed(t) > 32'sd32767) begin
      r = 16'h7FFF;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/barometric_pressure_compensation_core.sv
// Integer temperature and pressure compensation of a barometric sensor reading pair,
// using calibration words written over the cfg port while idle. One word is taken
// every cycle while the output is not stalled; each result passes through two 32-step
// restoring dividers (temperature term, then pressure) and the multiplier stages
// around them. A stall while the output holds a word freezes the whole pipeline. A zero
// divisor yields zero results with divide_fault set.
module barometric_pressure_compensation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        raw_temperature_i,
  input  logic [18:0]        raw_pressure_i,
  output logic               out_valid_o,
  input  logic               stall_i,
  output logic signed [15:0] temperature_tenths_o,
  output logic signed [31:0] pressure_pa_o,
  output logic               divide_fault_o
);
  import bpc_pkg::*;
  `include "barometric_pressure_compensation_core_macros.svh"

  logic [63:0] cal_a_q, cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal_a_q[63]}}, cal_a_q[63:48]};
  assign ac2 = {{16{cal_a_q[47]}}, cal_a_q[47:32]};
  assign ac3 = {{16{cal_a_q[31]}}, cal_a_q[31:16]};
  assign ac4 = {16'd0, cal_a_q[15:0]};
  assign ac5 = {16'd0, cal_b_q[63:48]};
  assign ac6 = {16'd0, cal_b_q[47:32]};
  assign b1  = {{16{cal_b_q[31]}}, cal_b_q[31:16]};
  assign b2  = {{16{cal_b_q[15]}}, cal_b_q[15:0]};
  assign mc  = {{16{cal_c_q[31]}}, cal_c_q[31:16]};
  assign md  = {{16{cal_c_q[15]}}, cal_c_q[15:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CAL_A: cal_a_q <= cfg_wdata_i;
        CFG_CAL_B: cal_b_q <= cfg_wdata_i;
        CFG_CAL_C: cal_c_q <= cfg_wdata_i[31:0];
        CFG_OSS:   oss_q   <= cfg_wdata_i[1:0];
        default:   oss_q   <= oss_q;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !stall_i;
  assign in_stall_o = !en;

  // pipeline registers
  logic        s1_v_q;
  logic [31:0] s1_prod_q;
  logic [18:0] s1_up_q;

  logic       d1_v_q [0:DIV_STEPS];
  div_state_t d1_st_q[0:DIV_STEPS];
  div1_side_t d1_sd_q[0:DIV_STEPS];

  logic        p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q, p7_v_q;
  press_side_t p1_sd_q, p2_sd_q, p3_sd_q, p4_sd_q, p5_sd_q, p6_sd_q, p7_sd_q;
  logic [31:0] p1_b6_q;
  logic [31:0] p2_sqr_q, p2_ac2_q, p2_ac3_q;
  logic [31:0] p3_sq_q, p3_x2a_q, p3_x1c_q;
  logic [31:0] p4_b2sq_q, p4_b1sq_q, p4_x2a_q, p4_x1c_q;
  logic [31:0] p5_b3_q, p5_x3k_q;
  logic [31:0] p6_b4_q, p6_diff_q;
  logic [31:0] p7_b7_q, p7_b4_q;

  logic       d2_v_q [0:DIV_STEPS];
  div_state_t d2_st_q[0:DIV_STEPS];
  div2_side_t d2_sd_q[0:DIV_STEPS];

  logic        q1_v_q, q2_v_q, q3_v_q;
  logic [31:0] q1_p_q, q2_p_q, q3_p_q;
  logic [31:0] q2_x1_q, q2_x2m_q, q3_x1m_q, q3_x2m_q;
  logic        q1_f_q, q2_f_q, q3_f_q;
  logic [15:0] q1_ts_q, q2_ts_q, q3_ts_q;

  logic [15:0] out_temp_q;
  logic [31:0] out_press_q;
  logic        out_fault_q;

  // combinational helpers
  logic [31:0] s2_x1t, s2_den, s2_num;
  assign s2_x1t = asr(s1_prod_q, 5'd15);
  assign s2_den = s2_x1t + md;
  assign s2_num = mc << 11;

  logic [31:0] p1_x2, p1_b5, p1_t;
  assign p1_x2 = d1_sd_q[DIV_STEPS].neg ? 32'd0 - d1_st_q[DIV_STEPS].quo
                                        : d1_st_q[DIV_STEPS].quo;
  assign p1_b5 = d1_sd_q[DIV_STEPS].x1t + p1_x2;
  assign p1_t  = asr(p1_b5 + 32'd8, 5'd4);

  logic [31:0] p5_x3, p5_x3b;
  assign p5_x3  = asr(p4_b2sq_q, 5'd11) + p4_x2a_q;
  assign p5_x3b = asr(p4_x1c_q + asr(p4_b1sq_q, 5'd16) + 32'd2, 5'd2);

  logic [31:0] p6_prod;
  assign p6_prod = ac4 * p5_x3k_q;

  logic [31:0] q2_a;
  assign q2_a = asr(q1_p_q, 5'd8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      p4_v_q      <= 1'b0;
      p5_v_q      <= 1'b0;
      p6_v_q      <= 1'b0;
      p7_v_q      <= 1'b0;
      q1_v_q      <= 1'b0;
      q2_v_q      <= 1'b0;
      q3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        d1_v_q[k] <= 1'b0;
        d2_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      s1_v_q    <= in_valid_i;
      d1_v_q[0] <= s1_v_q;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        d1_v_q[k] <= d1_v_q[k-1];
        d2_v_q[k] <= d2_v_q[k-1];
      end
      p1_v_q      <= d1_v_q[DIV_STEPS];
      p2_v_q      <= p1_v_q;
      p3_v_q      <= p2_v_q;
      p4_v_q      <= p3_v_q;
      p5_v_q      <= p4_v_q;
      p6_v_q      <= p5_v_q;
      p7_v_q      <= p6_v_q;
      d2_v_q[0]   <= p7_v_q;
      q1_v_q      <= d2_v_q[DIV_STEPS];
      q2_v_q      <= q1_v_q;
      q3_v_q      <= q2_v_q;
      out_valid_q <= q3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= ({16'd0, raw_temperature_i} - ac6) * ac5;
      s1_up_q   <= raw_pressure_i;

      d1_st_q[0].rem   <= '0;
      d1_st_q[0].quo   <= s2_num[31] ? 32'd0 - s2_num : s2_num;
      d1_sd_q[0].fault <= (s2_den == '0);
      d1_sd_q[0].neg   <= s2_num[31] ^ s2_den[31];
      d1_sd_q[0].x1t   <= s2_x1t;
      d1_sd_q[0].up    <= s1_up_q;
      d1_sd_q[0].dvs   <= s2_den[31] ? 32'd0 - s2_den : s2_den;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        d1_st_q[k] <= div_step(d1_st_q[k-1], d1_sd_q[k-1].dvs);
        d1_sd_q[k] <= d1_sd_q[k-1];
        d2_st_q[k] <= div_step(d2_st_q[k-1], d2_sd_q[k-1].dvs);
        d2_sd_q[k] <= d2_sd_q[k-1];
      end

      p1_b6_q       <= p1_b5 - TEMP_OFFSET;
      p1_sd_q.fault <= d1_sd_q[DIV_STEPS].fault;
      p1_sd_q.ts    <= sat16(p1_t);
      p1_sd_q.up    <= d1_sd_q[DIV_STEPS].up;

      p2_sqr_q <= p1_b6_q * p1_b6_q;
      p2_ac2_q <= ac2 * p1_b6_q;
      p2_ac3_q <= ac3 * p1_b6_q;
      p2_sd_q  <= p1_sd_q;

      p3_sq_q  <= asr(p2_sqr_q, 5'd12);
      p3_x2a_q <= asr(p2_ac2_q, 5'd11);
      p3_x1c_q <= asr(p2_ac3_q, 5'd13);
      p3_sd_q  <= p2_sd_q;

      p4_b2sq_q <= b2 * p3_sq_q;
      p4_b1sq_q <= b1 * p3_sq_q;
      p4_x2a_q  <= p3_x2a_q;
      p4_x1c_q  <= p3_x1c_q;
      p4_sd_q   <= p3_sd_q;

      p5_b3_q  <= asr((((ac1 << 2) + p5_x3) << oss_q) + 32'd2, 5'd2);
      p5_x3k_q <= p5_x3b + X3_BIAS;
      p5_sd_q  <= p4_sd_q;

      p6_b4_q   <= p6_prod >> 15;
      p6_diff_q <= {13'd0, p5_sd_q.up} - p5_b3_q;
      p6_sd_q   <= p5_sd_q;

      p7_b7_q       <= p6_diff_q * (P_SCALE >> oss_q);
      p7_b4_q       <= p6_b4_q;
      p7_sd_q.fault <= p6_sd_q.fault | (p6_b4_q == '0);
      p7_sd_q.ts    <= p6_sd_q.ts;
      p7_sd_q.up    <= p6_sd_q.up;

      d2_st_q[0].rem   <= '0;
      d2_st_q[0].quo   <= ((p7_b7_q & SIGN_BIT) != '0) ? p7_b7_q : p7_b7_q << 1;
      d2_sd_q[0].fault <= p7_sd_q.fault;
      d2_sd_q[0].shl   <= ((p7_b7_q & SIGN_BIT) != '0);
      d2_sd_q[0].ts    <= p7_sd_q.ts;
      d2_sd_q[0].dvs   <= p7_b4_q;

      q1_p_q  <= d2_sd_q[DIV_STEPS].shl ? d2_st_q[DIV_STEPS].quo << 1
                                        : d2_st_q[DIV_STEPS].quo;
      q1_f_q  <= d2_sd_q[DIV_STEPS].fault;
      q1_ts_q <= d2_sd_q[DIV_STEPS].ts;

      q2_x1_q  <= q2_a * q2_a;
      q2_x2m_q <= P_COEF_LIN * q1_p_q;
      q2_p_q   <= q1_p_q;
      q2_f_q   <= q1_f_q;
      q2_ts_q  <= q1_ts_q;

      q3_x1m_q <= q2_x1_q * P_COEF_SQ;
      q3_x2m_q <= q2_x2m_q;
      q3_p_q   <= q2_p_q;
      q3_f_q   <= q2_f_q;
      q3_ts_q  <= q2_ts_q;

      out_fault_q <= q3_f_q;
      out_temp_q  <= q3_f_q ? '0 : q3_ts_q;
      out_press_q <= q3_f_q ? '0 : q3_p_q + asr(asr(q3_x1m_q, 5'd16)
                     + asr(q3_x2m_q, 5'd16) + P_COEF_OFS, 5'd4);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign temperature_tenths_o = $signed(out_temp_q);
  assign pressure_pa_o        = $signed(out_press_q);
  assign divide_fault_o       = out_fault_q;

  `BPC_ASSERT_IMPL(a_fault_zero, out_valid_o && divide_fault_o,
    pressure_pa_o == '0 && temperature_tenths_o == '0, "fault word has nonzero results")
  `BPC_ASSERT_IMPL(a_empty_no_stall, !out_valid_o, !in_stall_o,
    "input stalled with empty output register")
  `BPC_ASSERT_NEXT(a_freeze, in_stall_o,
    $stable(s1_v_q) && $stable(p4_v_q) && $stable(q3_v_q), "pipeline moved while stalled")
endmodule

FILE: tb/bpc_compensation_monitor.sv
`timescale 1ns / 100ps

module bpc_compensation_monitor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [15:0]        raw_temperature_i,
  input  logic [18:0]        raw_pressure_i,
  input  logic               out_valid_i,
  input  logic               stall_i,
  input  logic signed [15:0] temperature_tenths_i,
  input  logic signed [31:0] pressure_pa_i,
  input  logic               divide_fault_i,
  output int                 error_count_o,
  output int                 pending_o
);
  import bpc_pkg::*;

  typedef struct packed {
    logic [15:0] temp;
    logic [31:0] press;
    logic        fault;
  } reading_t;

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss_q;
  reading_t    expected_readings[$];
  int          errors;

  assign error_count_o = errors;
  assign pending_o     = expected_readings.size();

  function automatic logic [31:0] sra32(logic [31:0] v, int n);
    logic signed [31:0] s;
    s = $signed(v) >>> n;
    return s;
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] d);
    logic [31:0] ma, md, q;
    ma = a[31] ? -a : a;
    md = d[31] ? -d : d;
    q  = ma / md;
    return (a[31] != d[31]) ? -q : q;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut16, logic [18:0] up19);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den, t;
    reading_t r;
    ac1 = sext16(cal_a[63:48]);
    ac2 = sext16(cal_a[47:32]);
    ac3 = sext16(cal_a[31:16]);
    ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]};
    ac6 = {16'd0, cal_b[47:32]};
    b1  = sext16(cal_b[31:16]);
    b2  = sext16(cal_b[15:0]);
    mc  = sext16(cal_c[31:16]);
    md  = sext16(cal_c[15:0]);
    ut  = {16'd0, ut16};
    up  = {13'd0, up19};
    r   = '{temp: 16'd0, press: 32'd0, fault: 1'b1};
    x1  = sra32((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 32'd0) return r;
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    t  = sra32(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = sra32(b6 * b6, 12);
    x1 = sra32(b2 * sq, 11);
    x2 = sra32(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra32(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 2);
    x1 = sra32(ac3 * b6, 13);
    x2 = sra32(b1 * sq, 16);
    x3 = sra32(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 32'd0) return r;
    b7 = (up - b3) * (32'd50000 >> oss_q);
    if (!b7[31]) p = (b7 << 1) / b4;
    else         p = (b7 / b4) << 1;
    x1 = sra32(p, 8) * sra32(p, 8);
    x1 = sra32(x1 * 32'd3038, 16);
    x2 = sra32(32'hFFFF_E343 * p, 16);
    p  = p + sra32(x1 + x2 + 32'd3791, 4);
    if ($signed(t) < -32'sd32768)     r.temp = 16'h8000;
    else if ($signed(t) > 32'sd32767) r.temp = 16'h7FFF;
    else                              r.temp = t[15:0];
    r.press = p;
    r.fault = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t e;
    if (!rst_ni) begin
      cal_a  <= '0;
      cal_b  <= '0;
      cal_c  <= '0;
      oss_q  <= '0;
      errors = 0;
      expected_readings.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CAL_A: cal_a <= cfg_wdata_i;
          CFG_CAL_B: cal_b <= cfg_wdata_i;
          CFG_CAL_C: cal_c <= cfg_wdata_i[31:0];
          CFG_OSS:   oss_q <= cfg_wdata_i[1:0];
          default:   ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_readings.push_back(compensate(raw_temperature_i, raw_pressure_i));
      if (out_valid_i && !stall_i) begin
        if (expected_readings.size() == 0) begin
          $display("unexpected word at %0t", $time);
          errors++;
        end else begin
          e = expected_readings.pop_front();
          if (temperature_tenths_i !== e.temp)
            report_mismatch("temperature", {16'd0, temperature_tenths_i}, {16'd0, e.temp});
          if (pressure_pa_i !== e.press)
            report_mismatch("pressure", pressure_pa_i, e.press);
          if (divide_fault_i !== e.fault)
            report_mismatch("fault", {31'd0, divide_fault_i}, {31'd0, e.fault});
        end
      end
    end
  end
endmodule

FILE: tb/barometric_pressure_compensation_core_test.sv
`timescale 1ns / 100ps

module barometric_pressure_compensation_core_test;
  import bpc_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [63:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [15:0]        raw_temperature_i = '0;
  logic [18:0]        raw_pressure_i = '0;
  logic               out_valid_o;
  logic               stall_i = 1'b0;
  logic signed [15:0] temperature_tenths_o;
  logic signed [31:0] pressure_pa_o;
  logic               divide_fault_o;
  int                 error_count, pending;
  int                 hold_go = 0, hold_taken = 0, hold_cnt = 0;
  int                 stall_mode = 0, idle_cycles = 0, burst_left = 0;
  int                 stall_phase = 0;

  always #2 clk_i = ~clk_i;

  barometric_pressure_compensation_core u_dut (.*);

  bpc_compensation_monitor u_monitor (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .raw_temperature_i, .raw_pressure_i,
    .out_valid_i(out_valid_o), .stall_i,
    .temperature_tenths_i(temperature_tenths_o), .pressure_pa_i(pressure_pa_o),
    .divide_fault_i(divide_fault_o),
    .error_count_o(error_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_go != hold_taken) begin
      hold_taken <= hold_go;
      hold_cnt   <= 400;
      stall_i    <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      stall_i  <= 1'b1;
    end else begin
      case (stall_mode)
        0: stall_i <= 1'b0;
        1: stall_i <= ($urandom_range(0, 3) == 0);
        2: stall_i <= (stall_phase % 5 < 2);
        default: stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("barometric_pressure_compensation_core_test: done, errors");
      $finish;
    end
  end

  task automatic write_cal(logic [63:0] a, logic [63:0] b, logic [31:0] c, logic [1:0] oss);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_CAL_A; cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_index_i <= CFG_CAL_B; cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_index_i <= CFG_CAL_C; cfg_wdata_i <= {$urandom, c};
    @(posedge clk_i);
    cfg_index_i <= CFG_OSS; cfg_wdata_i <= {$urandom, $urandom} & ~64'd3 | oss;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending == 0);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic send_word(logic [15:0] ut, logic [18:0] up);
    logic st;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    raw_temperature_i <= ut;
    raw_pressure_i <= up;
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  task automatic send_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        send_word(16'($urandom), 19'($urandom));
      else
        send_word(16'($urandom_range(20000, 36000)), 19'($urandom_range(15000, 120000)));
    end
    stop_sending();
  endtask

  localparam logic [63:0] TYP_A = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
  localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'd6190, 16'd4};
  localparam logic [31:0] TYP_C = {16'hDDF9, 16'd2868};

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(16'd0, 19'd0);
    send_word(16'hFFFF, 19'h7FFFF);
    stop_sending();
    drain();
    write_cal(TYP_A, TYP_B, TYP_C, 2'd0);
    send_word(16'd27898, 19'd23843);
    send_word(16'd0, 19'd0);
    send_word(16'hFFFF, 19'h7FFFF);
    send_word(16'd0, 19'h7FFFF);
    send_word(16'hFFFF, 19'd0);
    send_word(16'd23153, 19'd40000);
    stop_sending();
    drain();
    // temperature divisor zero: x1 + md == 0
    write_cal(TYP_A, {16'd0, 16'd23153, 16'd6190, 16'd4}, {16'hDDF9, 16'd0}, 2'd3);
    send_word(16'd27898, 19'd23843);
    send_word(16'hFFFF, 19'h7FFFF);
    stop_sending();
    drain();
    // pressure divisor zero: b4 == 0
    write_cal({TYP_A[63:16], 16'd0}, TYP_B, TYP_C, 2'd1);
    send_word(16'd27898, 19'd23843);
    send_word(16'd30000, 19'd90000);
    stop_sending();
    drain();
    write_cal('1, '1, '1, 2'd3);
    send_word(16'd0, 19'd0);
    send_word(16'hFFFF, 19'h7FFFF);
    stop_sending();
    drain();
    write_cal({4{16'h8000}}, {4{16'h8000}}, {2{16'h8000}}, 2'd2);
    send_word(16'd0, 19'h7FFFF);
    send_word(16'hFFFF, 19'd0);
    stop_sending();
    drain();
    write_cal({4{16'h7FFF}}, {4{16'h7FFF}}, {2{16'h7FFF}}, 2'd1);
    send_word(16'h8000, 19'h40000);
    send_word(16'h7FFF, 19'h3FFFF);
    stop_sending();
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 2)
        write_cal({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 2'($urandom));
      else
        write_cal(TYP_A ^ {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF,
                  TYP_B ^ {$urandom, $urandom} & 64'h00FF_00FF_00FF_000F,
                  TYP_C ^ ($urandom & 32'h00FF_00FF), 2'(ph));
      if (ph == 4) hold_go = hold_go + 1;
      send_random(120);
      drain();
    end
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0)
      $display("barometric_pressure_compensation_core_test: done, clean");
    else
      $display("barometric_pressure_compensation_core_test: done, errors");
    $finish;
  end
endmodule
